// File: hw/rtl/tw_pkg.sv
package tw_pkg;

  localparam int unsigned TW_WORD_W = 32;
  localparam int unsigned TW_RC_W = 16;
  localparam int unsigned TW_RC_IDX_W = 4;
  localparam int unsigned TW_RC_DEPTH = 12;
  localparam int unsigned TW_ROUND_CNT_W = 4;
  localparam int unsigned TW_MAX_ROUNDS = 11;
  localparam logic [TW_ROUND_CNT_W-1:0] TW_ROUND_COUNT_RST = 4'd11;

  typedef logic [TW_WORD_W-1:0] word_t;
  typedef logic [2:0][TW_WORD_W-1:0] blk_t;
  typedef logic [TW_RC_W-1:0] rc_t;

  typedef enum logic [1:0] {
    RegKeyWord0   = 2'd0,
    RegKeyWord1   = 2'd1,
    RegKeyWord2   = 2'd2,
    RegRoundCount = 2'd3
  } tw_reg_e;

  typedef struct packed {
    logic load;
    logic round;
    logic final_add;
  } tw_cmd_t;

  typedef struct packed {
    logic rounds_done;
  } tw_sts_t;

  localparam rc_t TW_ENC_RC [TW_RC_DEPTH] = '{
    16'h0B0B, 16'h1616, 16'h2C2C, 16'h5858, 16'hB0B0, 16'h7171,
    16'hE2E2, 16'hD5D5, 16'hBBBB, 16'h6767, 16'hCECE, 16'h8D8D
  };

  localparam rc_t TW_DEC_RC [TW_RC_DEPTH] = '{
    16'hB1B1, 16'h7373, 16'hE6E6, 16'hDDDD, 16'hABAB, 16'h4747,
    16'h8E8E, 16'h0D0D, 16'h1A1A, 16'h3434, 16'h6868, 16'hD0D0
  };

  function automatic rc_t rc_lookup(input logic dec, input logic [TW_RC_IDX_W-1:0] idx);
    rc_t r;
    r = '0;
    if (32'(idx) < TW_RC_DEPTH) begin
      r = dec ? TW_DEC_RC[idx] : TW_ENC_RC[idx];
    end
    return r;
  endfunction

  function automatic word_t rotl(input word_t v, input int unsigned n);
    return (v << n) | (v >> (TW_WORD_W - n));
  endfunction

  function automatic word_t bit_rev(input word_t v);
    word_t r;
    for (int i = 0; i < TW_WORD_W; i++) begin
      r[i] = v[TW_WORD_W-1-i];
    end
    return r;
  endfunction

  function automatic blk_t mu(input blk_t w);
    blk_t r;
    r[0] = bit_rev(w[2]);
    r[1] = bit_rev(w[1]);
    r[2] = bit_rev(w[0]);
    return r;
  endfunction

  function automatic blk_t theta(input blk_t w);
    word_t c;
    word_t a;
    word_t b;
    blk_t r;
    c = w[0] ^ w[1] ^ w[2];
    c = rotl(c, 16) ^ rotl(c, 8);
    a = (w[0] << 24) ^ (w[2] >> 8) ^ (w[1] << 8) ^ (w[0] >> 24);
    b = (w[1] << 24) ^ (w[0] >> 8) ^ (w[2] << 8) ^ (w[1] >> 24);
    r[0] = w[0] ^ c ^ a;
    r[1] = w[1] ^ c ^ b;
    r[2] = w[2] ^ c ^ (a >> 16) ^ (b << 16);
    return r;
  endfunction

  function automatic blk_t gamma_mix(input blk_t w);
    word_t r0;
    word_t r2;
    blk_t r;
    r2 = rotl(w[2], 1);
    r0 = rotl(w[0], 22);
    r[0] = rotl(r0 ^ (w[1] | ~r2), 1);
    r[2] = rotl(r2 ^ (r0 | ~w[1]), 22);
    r[1] = w[1] ^ (r2 | ~r0);
    return r;
  endfunction

  function automatic blk_t add_key(input blk_t w, input blk_t k, input rc_t rc);
    blk_t r;
    r[0] = w[0] ^ k[0] ^ {rc, 16'h0000};
    r[1] = w[1] ^ k[1];
    r[2] = w[2] ^ k[2] ^ {16'h0000, rc};
    return r;
  endfunction

endpackage

// File: hw/rtl/threeway_block_cipher_core.sv
// Channel   Direction  Handshake                Payload
// request   in         start_i / busy_o         mode_i, data_word0_i..data_word2_i
// result    out        done_o (one-cycle)       out_word0_o..out_word2_o
// config    in         cfg_we_i                 cfg_idx_i, cfg_wdata_i
//
// A request runs R rounds, R being the selected round count (11 by default):
// one shared round unit runs the first round in the accept cycle and one round per cycle
// after it, then the final key add and theta.
// done_o pulses in the cycle after the final key add, with busy_o already low: a new request
// may be accepted in that same cycle. Results cannot be stalled.
// Reset clears the key words and derived decrypt key and sets the round count to 11.
module threeway_block_cipher_core
  import tw_pkg::*;
#(
  parameter int unsigned MAX_ROUNDS = TW_MAX_ROUNDS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  output logic                 done_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [TW_WORD_W-1:0] cfg_wdata_i,
  input  logic                 mode_i,
  input  logic [TW_WORD_W-1:0] data_word0_i,
  input  logic [TW_WORD_W-1:0] data_word1_i,
  input  logic [TW_WORD_W-1:0] data_word2_i,
  output logic [TW_WORD_W-1:0] out_word0_o,
  output logic [TW_WORD_W-1:0] out_word1_o,
  output logic [TW_WORD_W-1:0] out_word2_o
);

  tw_cmd_t cmd;
  tw_sts_t sts;

  tw_ctrl u_tw_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  tw_datapath #(
    .MAX_ROUNDS (MAX_ROUNDS)
  ) u_tw_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .mode_i       (mode_i),
    .data_word0_i (data_word0_i),
    .data_word1_i (data_word1_i),
    .data_word2_i (data_word2_i),
    .out_word0_o  (out_word0_o),
    .out_word1_o  (out_word1_o),
    .out_word2_o  (out_word2_o)
  );

endmodule

// File: hw/rtl/tw_ctrl.sv
module tw_ctrl
  import tw_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  tw_sts_t sts_i,
  output tw_cmd_t cmd_o,
  output logic    busy_o,
  output logic    done_o
);

  typedef enum logic {
    StIdle,
    StRun
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   done_q;

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      StIdle: begin
        cmd_o.load = start_i;
      end
      StRun: begin
        cmd_o.round     = !sts_i.rounds_done;
        cmd_o.final_add = sts_i.rounds_done;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (start_i) begin
            state_q <= StRun;
            busy_q  <= 1'b1;
          end
        end
        StRun: begin
          if (sts_i.rounds_done) begin
            state_q <= StIdle;
            busy_q  <= 1'b0;
            done_q  <= 1'b1;
          end
        end
        default: begin
          state_q <= StIdle;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

// File: hw/rtl/tw_datapath.sv
module tw_datapath
  import tw_pkg::*;
#(
  parameter int unsigned MAX_ROUNDS = TW_MAX_ROUNDS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [TW_WORD_W-1:0] cfg_wdata_i,
  input  tw_cmd_t              cmd_i,
  output tw_sts_t              sts_o,
  input  logic                 mode_i,
  input  logic [TW_WORD_W-1:0] data_word0_i,
  input  logic [TW_WORD_W-1:0] data_word1_i,
  input  logic [TW_WORD_W-1:0] data_word2_i,
  output logic [TW_WORD_W-1:0] out_word0_o,
  output logic [TW_WORD_W-1:0] out_word1_o,
  output logic [TW_WORD_W-1:0] out_word2_o
);

  localparam int unsigned CntW = $clog2(MAX_ROUNDS + 1);

  blk_t                      key_q, key_d;
  blk_t                      dkey_q;
  logic [TW_ROUND_CNT_W-1:0] round_count_q;
  logic [CntW-1:0]           rounds_sel;
  logic [CntW-1:0]           cnt_q;
  logic                      mode_q;
  blk_t                      w_q;
  blk_t                      out_q;

  blk_t                      blk_in;
  blk_t                      src;
  blk_t                      key_sel;
  blk_t                      mixed;
  logic                      mode_sel;
  logic [TW_RC_IDX_W-1:0]    rc_idx;
  rc_t                       rc;

  always_comb begin
    key_d = key_q;
    if (cfg_we_i) begin
      unique case (tw_reg_e'(cfg_idx_i))
        RegKeyWord0:   key_d[0] = cfg_wdata_i;
        RegKeyWord1:   key_d[1] = cfg_wdata_i;
        RegKeyWord2:   key_d[2] = cfg_wdata_i;
        RegRoundCount: key_d = key_q;
        default:       key_d = key_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q         <= '0;
      dkey_q        <= '0;
      round_count_q <= TW_ROUND_COUNT_RST;
    end else if (cfg_we_i) begin
      key_q  <= key_d;
      dkey_q <= mu(theta(key_d));
      if (tw_reg_e'(cfg_idx_i) == RegRoundCount) begin
        round_count_q <= cfg_wdata_i[TW_ROUND_CNT_W-1:0];
      end
    end
  end

  always_comb begin
    if (round_count_q == '0 || round_count_q > TW_ROUND_CNT_W'(MAX_ROUNDS)) begin
      rounds_sel = CntW'(MAX_ROUNDS);
    end else begin
      rounds_sel = CntW'(round_count_q);
    end
  end

  assign sts_o.rounds_done = (cnt_q == rounds_sel);

  always_comb begin
    blk_in[0] = data_word0_i;
    blk_in[1] = data_word1_i;
    blk_in[2] = data_word2_i;
    mode_sel  = cmd_i.load ? mode_i : mode_q;
    if (cmd_i.load) begin
      src    = mode_i ? mu(blk_in) : blk_in;
      rc_idx = '0;
    end else begin
      src    = w_q;
      rc_idx = TW_RC_IDX_W'(cnt_q);
    end
    key_sel = mode_sel ? dkey_q : key_q;
    rc      = rc_lookup(mode_sel, rc_idx);
    mixed   = theta(add_key(src, key_sel, rc));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.load) begin
      cnt_q <= CntW'(1);
    end else if (cmd_i.round) begin
      cnt_q <= cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load || cmd_i.round) begin
      w_q <= gamma_mix(mixed);
    end
    if (cmd_i.load) begin
      mode_q <= mode_i;
    end
    if (cmd_i.final_add) begin
      out_q <= mode_q ? mu(mixed) : mixed;
    end
  end

  assign out_word0_o = out_q[0];
  assign out_word1_o = out_q[1];
  assign out_word2_o = out_q[2];

endmodule

// File: hw/rtl/tw_checker.sv
module tw_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("request accepted but block not busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o ##1 !busy_o |-> done_o)
    else $error("request finished without a result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o && !start_i |=> !busy_o && !done_o)
    else $error("activity without a request");

endmodule

bind threeway_block_cipher_core tw_checker u_tw_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o)
);

// File: tb/threeway_block_cipher_core_test.sv
module threeway_block_cipher_core_test;
  import tw_pkg::*;

  typedef struct {
    logic  decrypt;
    word_t w0;
    word_t w1;
    word_t w2;
  } block_req_t;

  localparam int unsigned CYCLE_LIMIT = 400000;

  localparam logic [15:0] ENC_RC_TAB [12] = '{
    16'h0B0B, 16'h1616, 16'h2C2C, 16'h5858, 16'hB0B0, 16'h7171,
    16'hE2E2, 16'hD5D5, 16'hBBBB, 16'h6767, 16'hCECE, 16'h8D8D
  };
  localparam logic [15:0] DEC_RC_TAB [12] = '{
    16'hB1B1, 16'h7373, 16'hE6E6, 16'hDDDD, 16'hABAB, 16'h4747,
    16'h8E8E, 16'h0D0D, 16'h1A1A, 16'h3434, 16'h6868, 16'hD0D0
  };

  logic       clk_i;
  logic       rst_ni;
  logic       start_i;
  logic       busy_o;
  logic       done_o;
  logic       cfg_we_i;
  logic [1:0] cfg_idx_i;
  word_t      cfg_wdata_i;
  logic       mode_i;
  word_t      data_word0_i;
  word_t      data_word1_i;
  word_t      data_word2_i;
  word_t      out_word0_o;
  word_t      out_word1_o;
  word_t      out_word2_o;

  blk_t        key_blk;
  blk_t        inv_key;
  logic [3:0]  round_sel;
  block_req_t  block_req_q[$];
  blk_t        cipher_expect_q[$];
  logic        took_req;
  logic        steady;
  int unsigned idle_left;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  blk_t        seen_blk;
  blk_t        want_blk;
  block_req_t  next_req;

  threeway_block_cipher_core u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .done_o       (done_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .mode_i       (mode_i),
    .data_word0_i (data_word0_i),
    .data_word1_i (data_word1_i),
    .data_word2_i (data_word2_i),
    .out_word0_o  (out_word0_o),
    .out_word1_o  (out_word1_o),
    .out_word2_o  (out_word2_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic word_t rot_left(word_t v, int unsigned n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic word_t flip_bits(word_t v);
    word_t r;
    for (int i = 0; i < 32; i++) begin
      r[i] = v[31-i];
    end
    return r;
  endfunction

  function automatic blk_t mirror96(blk_t w);
    blk_t r;
    r[0] = flip_bits(w[2]);
    r[1] = flip_bits(w[1]);
    r[2] = flip_bits(w[0]);
    return r;
  endfunction

  function automatic blk_t mix_theta(blk_t w);
    word_t c;
    word_t a;
    word_t b;
    blk_t  r;
    c = w[0] ^ w[1] ^ w[2];
    c = rot_left(c, 16) ^ rot_left(c, 8);
    a = (w[0] << 24) ^ (w[2] >> 8) ^ (w[1] << 8) ^ (w[0] >> 24);
    b = (w[1] << 24) ^ (w[0] >> 8) ^ (w[2] << 8) ^ (w[1] >> 24);
    r[0] = w[0] ^ c ^ a;
    r[1] = w[1] ^ c ^ b;
    r[2] = w[2] ^ c ^ (a >> 16) ^ (b << 16);
    return r;
  endfunction

  function automatic blk_t nonlin_step(blk_t w);
    word_t r0;
    word_t r2;
    blk_t  r;
    r2 = rot_left(w[2], 1);
    r0 = rot_left(w[0], 22);
    r[0] = rot_left(r0 ^ (w[1] | ~r2), 1);
    r[2] = rot_left(r2 ^ (r0 | ~w[1]), 22);
    r[1] = w[1] ^ (r2 | ~r0);
    return r;
  endfunction

  function automatic blk_t inject_key(blk_t w, blk_t k, logic [15:0] rc);
    blk_t r;
    r[0] = w[0] ^ k[0] ^ {rc, 16'h0000};
    r[1] = w[1] ^ k[1];
    r[2] = w[2] ^ k[2] ^ {16'h0000, rc};
    return r;
  endfunction

  function automatic blk_t cipher_block(logic decrypt, blk_t din);
    blk_t        w;
    blk_t        k;
    int unsigned nr;
    logic [15:0] rc;
    nr = (round_sel == 4'd0 || round_sel > 4'd11) ? 11 : int'(round_sel);
    w = din;
    k = key_blk;
    if (decrypt) begin
      k = inv_key;
      w = mirror96(w);
    end
    for (int i = 0; i < nr; i++) begin
      rc = decrypt ? DEC_RC_TAB[i] : ENC_RC_TAB[i];
      w = nonlin_step(mix_theta(inject_key(w, k, rc)));
    end
    rc = decrypt ? DEC_RC_TAB[nr] : ENC_RC_TAB[nr];
    w = mix_theta(inject_key(w, k, rc));
    if (decrypt) begin
      w = mirror96(w);
    end
    return w;
  endfunction

  function automatic word_t random_word();
    int unsigned r;
    r = $urandom_range(0, 15);
    case (r)
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return word_t'(1) << $urandom_range(0, 31);
      3: return ~(word_t'(1) << $urandom_range(0, 31));
      default: return $urandom;
    endcase
  endfunction

  function automatic int unsigned draw_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(13, 40);
  endfunction

  task automatic queue_block(logic decrypt, word_t w0, word_t w1, word_t w2);
    block_req_t req;
    req.decrypt = decrypt;
    req.w0 = w0;
    req.w1 = w1;
    req.w2 = w2;
    block_req_q.push_back(req);
  endtask

  task automatic write_reg(tw_reg_e idx, word_t data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    case (idx)
      RegKeyWord0:   key_blk[0] = data;
      RegKeyWord1:   key_blk[1] = data;
      RegKeyWord2:   key_blk[2] = data;
      RegRoundCount: round_sel = data[3:0];
      default: ;
    endcase
    inv_key = mirror96(mix_theta(key_blk));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (block_req_q.size() != 0 || cipher_expect_q.size() != 0 || start_i) begin
      @(posedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start_i      <= 1'b0;
      mode_i       <= 1'b0;
      data_word0_i <= '0;
      data_word1_i <= '0;
      data_word2_i <= '0;
      idle_left    <= 0;
      steady       <= 1'b0;
    end else if (!start_i || took_req) begin
      if (idle_left != 0) begin
        start_i   <= 1'b0;
        idle_left <= idle_left - 1;
      end else if (block_req_q.size() != 0) begin
        next_req = block_req_q.pop_front();
        start_i      <= 1'b1;
        mode_i       <= next_req.decrypt;
        data_word0_i <= next_req.w0;
        data_word1_i <= next_req.w1;
        data_word2_i <= next_req.w2;
        idle_left    <= draw_idle();
        if ($urandom_range(0, 49) == 0) begin
          steady <= ~steady;
        end
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      took_req <= 1'b0;
    end else begin
      took_req <= start_i && !busy_o;
      if (done_o) begin
        seen_blk = {out_word2_o, out_word1_o, out_word0_o};
        if (cipher_expect_q.size() == 0) begin
          mismatch_cnt = mismatch_cnt + 1;
          $display("%0t: unexpected result, expected none, actual %h %h %h", $time,
                   out_word0_o, out_word1_o, out_word2_o);
        end else begin
          want_blk = cipher_expect_q.pop_front();
          for (int j = 0; j < 3; j++) begin
            if (seen_blk[j] !== want_blk[j]) begin
              mismatch_cnt = mismatch_cnt + 1;
              $display("%0t: out_word%0d expected %h actual %h", $time, j,
                       want_blk[j], seen_blk[j]);
            end
          end
        end
      end
      if (start_i && !busy_o) begin
        cipher_expect_q.push_back(
          cipher_block(mode_i, {data_word2_i, data_word1_i, data_word0_i}));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int unsigned rounds_plan [10];
    word_t       rc_word;
    rounds_plan = '{11, 0, 1, 15, 6, 12, 3, 9, 2, 14};
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = RegKeyWord0;
    cfg_wdata_i  = '0;
    key_blk      = '0;
    round_sel    = TW_ROUND_COUNT_RST;
    inv_key      = mirror96(mix_theta(key_blk));
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    queue_block(1'b0, 32'h0, 32'h0, 32'h0);
    queue_block(1'b1, 32'h0, 32'h0, 32'h0);
    queue_block(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_block(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_idle();

    write_reg(RegKeyWord0, 32'hFFFF_FFFF);
    write_reg(RegKeyWord1, 32'hFFFF_FFFF);
    write_reg(RegKeyWord2, 32'hFFFF_FFFF);
    write_reg(RegRoundCount, 32'h0);
    queue_block(1'b0, 32'h8000_0000, 32'h0000_0001, 32'h0);
    queue_block(1'b1, 32'h8000_0000, 32'h0000_0001, 32'h0);
    queue_block(1'b0, 32'h0, 32'h0, 32'h0);
    queue_block(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_idle();

    write_reg(RegKeyWord0, 32'hAAAA_AAAA);
    write_reg(RegKeyWord1, 32'h5555_5555);
    write_reg(RegKeyWord2, 32'h0);
    write_reg(RegRoundCount, 32'h1);
    queue_block(1'b0, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF);
    queue_block(1'b1, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF);
    queue_block(1'b0, 32'h0, 32'hFFFF_FFFF, 32'h0);
    queue_block(1'b1, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    wait_idle();

    write_reg(RegRoundCount, 32'hFFFF_FFFF);
    queue_block(1'b0, 32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98);
    queue_block(1'b1, 32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98);
    queue_block(1'b0, 32'hFFFF_FFFF, 32'h0, 32'h0000_0001);
    wait_idle();

    write_reg(RegRoundCount, 32'd12);
    queue_block(1'b0, 32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98);
    queue_block(1'b1, 32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98);
    queue_block(1'b1, 32'h8000_0000, 32'h0, 32'h0000_0001);
    wait_idle();

    for (int ph = 0; ph < 10; ph++) begin
      write_reg(RegKeyWord0, random_word());
      write_reg(RegKeyWord1, random_word());
      write_reg(RegKeyWord2, random_word());
      rc_word = $urandom;
      rc_word[3:0] = rounds_plan[ph][3:0];
      write_reg(RegRoundCount, rc_word);
      repeat (145) begin
        queue_block(1'($urandom_range(0, 1)), random_word(), random_word(), random_word());
      end
      wait_idle();
    end

    repeat (30) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/tw_pkg.sv
hw/rtl/tw_ctrl.sv
hw/rtl/tw_datapath.sv
hw/rtl/threeway_block_cipher_core.sv
hw/rtl/tw_checker.sv
tb/threeway_block_cipher_core_test.sv
